>>> rtl/ars_pkg.sv
// ars_pkg: shared types, codes and constants of the attenuated ray sum block
// exp weight table entry function used at elaboration by ars_datapath
`timescale 1ns / 1ps

package ars_pkg;

    localparam int unsigned MAX_DEPTH      = 256;
    localparam int unsigned EXP_TABLE_BITS = 8;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;

    localparam logic [1:0] MODE_BOTH     = 2'd0;
    localparam logic [1:0] MODE_ACT_ONLY = 2'd1;
    localparam logic [1:0] MODE_ATT_ONLY = 2'd2;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    localparam logic [24:0] PATH_CAP = 25'h0FFFFFF;
    localparam logic [24:0] PATH_LIMIT =
        (64'(MAX_DEPTH) * 64'd65535 > 64'(PATH_CAP)) ? PATH_CAP
                                                     : 25'(MAX_DEPTH * 65535);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP,
        ST_WGT,
        ST_MUL,
        ST_ACC,
        ST_BG_MUL,
        ST_OUT
    } ars_state_t;

    typedef struct packed {
        logic capture;
        logic calc_exp;
        logic calc_wgt;
        logic calc_mul;
        logic sel_bg;
        logic acc_add;
        logic load_out;
    } ars_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } ars_status_t;

    // round(65536 * 2^(-idx / 2^bits)) by an integer series of exp(-y)
    function automatic logic [16:0] exp_table_entry(input int unsigned idx,
                                                    input int unsigned bits);
        logic [63:0] y;
        logic [63:0] term;
        longint      sum;
        y    = (64'(idx) * LN2_Q32) >> bits;
        term = 64'h1_0000_0000;
        sum  = longint'(term);
        term = ((term * y) >> 32) / 64'd1;  sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd2;  sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd3;  sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd4;  sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd5;  sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd6;  sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd7;  sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd8;  sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd9;  sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd10; sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd11; sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd12; sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd13; sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd14; sum = sum + longint'(term);
        term = ((term * y) >> 32) / 64'd15; sum = sum - longint'(term);
        term = ((term * y) >> 32) / 64'd16; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return 17'((64'(sum) + 64'd32768) >> 16);
    endfunction

endpackage

>>> rtl/ars_ctrl.sv
// ars_ctrl: sequencing state machine of the attenuated ray sum block
// depends on ars_pkg for the state type and command/status structs
`timescale 1ns / 1ps

module ars_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ars_pkg::ars_status_t status,
    output ars_pkg::ars_cmd_t   cmd
);
    import ars_pkg::*;

    ars_state_t state_reg;
    ars_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP:    state_next = ST_WGT;
            ST_WGT:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC: begin
                state_next = status.last ? ST_BG_MUL : ST_IDLE;
            end
            ST_BG_MUL: state_next = ST_OUT;
            ST_OUT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXP:    cmd.calc_exp = 1'b1;
            ST_WGT:    cmd.calc_wgt = 1'b1;
            ST_MUL:    cmd.calc_mul = 1'b1;
            ST_ACC:    cmd.acc_add  = 1'b1;
            ST_BG_MUL: begin
                cmd.calc_mul = 1'b1;
                cmd.sel_bg   = 1'b1;
            end
            ST_OUT: begin
                cmd.sel_bg   = 1'b1;
                cmd.load_out = !status.out_busy;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/ars_datapath.sv
// ars_datapath: config registers, path sum, exp weight, multiply and accumulator
// depends on ars_pkg; driven by ars_ctrl through ars_cmd_t
`timescale 1ns / 1ps

module ars_datapath #(
    parameter int unsigned EXP_TABLE_BITS = ars_pkg::EXP_TABLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ars_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ars_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [15:0]                        s_activity,
    input  logic [15:0]                        s_attenuation,
    input  logic                               s_last_of_ray,
    input  ars_pkg::ars_cmd_t                  cmd,
    output ars_pkg::ars_status_t               status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [31:0]                        m_projection,
    output logic                               m_saturated
);
    import ars_pkg::*;

    localparam int unsigned TABLE_SIZE = 1 << EXP_TABLE_BITS;

    logic [16:0] exp_tab [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_tab
        assign exp_tab[g] = exp_table_entry(g, EXP_TABLE_BITS);
    end

    logic [1:0]  mode_reg;
    logic [15:0] background_reg;
    logic [23:0] path_reg;
    logic [31:0] acc_reg;
    logic        ovf_reg;
    logic        out_valid_reg;

    logic [15:0] act_reg;
    logic        last_reg;
    logic [24:0] t_reg;
    logic [16:0] w_reg;
    logic [16:0] term_reg;
    logic [31:0] proj_reg;
    logic        sat_reg;

    logic        mode_act_only;
    logic        mode_att_only;
    logic [24:0] path_sum;
    logic [23:0] path_next;
    logic [40:0] t_prod;
    logic [12:0] t_int;
    logic [EXP_TABLE_BITS-1:0] t_idx;
    logic [16:0] w_next;
    logic [16:0] w_eff;
    logic [15:0] mul_operand;
    logic [32:0] mul_prod;
    logic [32:0] acc_sum;
    logic [31:0] acc_next;
    logic        ovf_next;

    assign cfg_ready     = 1'b1;
    assign mode_act_only = (mode_reg == MODE_ACT_ONLY);
    assign mode_att_only = (mode_reg == MODE_ATT_ONLY);

    always_comb begin
        path_sum  = 25'(path_reg) + 25'(s_attenuation);
        path_next = (path_sum > PATH_LIMIT) ? PATH_LIMIT[23:0] : path_sum[23:0];
    end

    always_comb begin
        t_prod = 41'(path_reg) * 41'(LOG2E_Q16);
        t_int  = t_reg[24:12];
        t_idx  = t_reg[11 -: EXP_TABLE_BITS];
        if (t_int >= 13'd17) begin
            w_next = '0;
        end else begin
            w_next = exp_tab[t_idx] >> t_int[4:0];
        end
    end

    always_comb begin
        w_eff       = mode_act_only ? WEIGHT_ONE : w_reg;
        mul_operand = cmd.sel_bg ? background_reg : act_reg;
        mul_prod    = 33'(mul_operand) * 33'(w_eff);
    end

    // saturating add of the current product term
    always_comb begin
        acc_sum = 33'(acc_reg) + 33'(term_reg);
        if (acc_sum[32]) begin
            acc_next = '1;
            ovf_next = 1'b1;
        end else begin
            acc_next = acc_sum[31:0];
            ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_BOTH;
            background_reg <= '0;
            path_reg       <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE:       mode_reg       <= cfg_data[1:0];
                    CFG_BACKGROUND: background_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.capture) begin
                path_reg <= path_next;
            end
            if (cmd.acc_add && !mode_att_only) begin
                acc_reg <= acc_next;
                ovf_reg <= ovf_next;
            end
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
                path_reg      <= '0;
                acc_reg       <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_activity;
            last_reg <= s_last_of_ray;
        end
        if (cmd.calc_exp) begin
            t_reg <= t_prod[40:16];
        end
        if (cmd.calc_wgt) begin
            w_reg <= w_next;
        end
        if (cmd.calc_mul) begin
            term_reg <= mul_prod[32:16];
        end
        if (cmd.load_out) begin
            if (mode_att_only) begin
                proj_reg <= 32'(term_reg);
                sat_reg  <= 1'b0;
            end else begin
                proj_reg <= acc_next;
                sat_reg  <= ovf_next;
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg;

    assign m_valid      = out_valid_reg;
    assign m_projection = proj_reg;
    assign m_saturated  = sat_reg;

endmodule

>>> rtl/attenuated_ray_sum.sv
// attenuated_ray_sum: top level of the attenuated ray sum projector
// depends on ars_pkg, ars_ctrl and ars_datapath
`timescale 1ns / 1ps

// usage
//   s_ channel: one voxel per transaction (activity Q8.8, attenuation Q4.12,
//   last_of_ray). m_ channel: one projection (Q24.8, saturating) and a
//   saturated flag per ray, sent after the voxel that carries last_of_ray.
//   cfg channel: register index 0 is mode, 1 is background level; writes
//   are taken in any cycle, cfg_ready stays high, unknown indexes are dropped.
// timing
//   a voxel steps the sequencer through accept, exp multiply, table lookup
//   and shift, weight multiply and accumulate, and a new voxel is taken
//   only after its accumulate step. a last voxel adds a background multiply
//   and an output load, which waits while an earlier result is still held.
// reset
//   aresetn low clears mode, background, the path sum, accumulator and
//   overflow flag and drops any pending result.
// stall
//   the result sits in an output register; the next ray's voxels are still
//   taken, and only the next ray end waits until the held result is taken.
module attenuated_ray_sum #(
    parameter int unsigned EXP_TABLE_BITS = ars_pkg::EXP_TABLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ars_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ars_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_activity,
    input  logic [15:0]                     s_attenuation,
    input  logic                            s_last_of_ray,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_projection,
    output logic                            m_saturated
);
    import ars_pkg::*;

    ars_cmd_t    cmd;
    ars_status_t status;

    ars_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ars_datapath #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_activity    (s_activity),
        .s_attenuation (s_attenuation),
        .s_last_of_ray (s_last_of_ray),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_projection  (m_projection),
        .m_saturated   (m_saturated)
    );

endmodule
